// File: hw/rtl/nfd_pkg.sv
// shared types and constants for the netstring frame decoder
// no dependencies; used by every module of the block
package nfd_pkg;

    localparam int LEN_BITS   = 16;
    localparam int ACC_BITS   = LEN_BITS + 4;
    localparam int MAX_DIGITS = 8;
    localparam int DC_BITS    = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_PREFIX    = 2'd1,
        ERR_TOO_LARGE = 2'd2,
        ERR_COMMA     = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_COMMA   = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           data;
        logic [LEN_BITS-1:0]  frame_length;
        t_err                 error_code;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hw/rtl/nfd_front.sv
// front part: takes stream bytes, tracks the netstring phase, builds results
// depends on nfd_pkg
module nfd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_max_length_we,
    input  logic [nfd_pkg::LEN_BITS-1:0]   i_max_length,
    input  logic                           i_valid,
    input  logic [7:0]                     i_byte,
    output logic                           o_ready,
    input  nfd_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output nfd_pkg::t_result               o_res
);

    logic [nfd_pkg::LEN_BITS-1:0] r_max_length;
    nfd_pkg::t_phase              r_phase, n_phase;
    logic [nfd_pkg::LEN_BITS-1:0] r_accum, n_accum;
    logic [nfd_pkg::LEN_BITS-1:0] r_left, n_left;
    logic [nfd_pkg::DC_BITS-1:0]  r_count, n_count;

    logic                         take;
    logic                         is_digit;
    logic [nfd_pkg::ACC_BITS-1:0] next_len;

    assign o_ready  = !i_q_stat.full;
    assign take     = i_valid && o_ready;
    assign is_digit = (i_byte >= nfd_pkg::CH_ZERO) && (i_byte <= nfd_pkg::CH_NINE);
    // accum * 10 + digit
    assign next_len = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                    + {{(nfd_pkg::ACC_BITS-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_left  = r_left;
        n_count = r_count;
        o_push  = 1'b0;
        o_res   = '0;
        if (take) begin
            unique case (r_phase)
                nfd_pkg::PH_PAYLOAD: begin
                    n_left = r_left - 1'b1;
                    if (r_left == nfd_pkg::LEN_BITS'(1)) begin
                        n_phase = nfd_pkg::PH_COMMA;
                    end
                    o_push      = 1'b1;
                    o_res.kind  = nfd_pkg::KIND_DATA;
                    o_res.data  = i_byte;
                end
                nfd_pkg::PH_COMMA: begin
                    n_phase = nfd_pkg::PH_PREFIX;
                    n_accum = '0;
                    n_left  = '0;
                    n_count = '0;
                    o_push  = 1'b1;
                    if (i_byte == nfd_pkg::CH_COMMA) begin
                        o_res.kind         = nfd_pkg::KIND_OK;
                        o_res.frame_length = r_accum;
                    end else begin
                        o_res.kind       = nfd_pkg::KIND_ERR;
                        o_res.error_code = nfd_pkg::ERR_COMMA;
                    end
                end
                default: begin
                    n_phase = nfd_pkg::PH_PREFIX;
                    if (is_digit) begin
                        if ((r_count >= nfd_pkg::DC_BITS'(nfd_pkg::MAX_DIGITS))
                            || (next_len > {4'b0000, r_max_length})) begin
                            n_accum          = '0;
                            n_left           = '0;
                            n_count          = '0;
                            o_push           = 1'b1;
                            o_res.kind       = nfd_pkg::KIND_ERR;
                            o_res.error_code = nfd_pkg::ERR_TOO_LARGE;
                        end else begin
                            n_accum = next_len[nfd_pkg::LEN_BITS-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end else if ((i_byte == nfd_pkg::CH_COLON) && (r_count != '0)) begin
                        n_left  = r_accum;
                        n_count = '0;
                        n_phase = (r_accum == '0) ? nfd_pkg::PH_COMMA : nfd_pkg::PH_PAYLOAD;
                    end else begin
                        n_accum          = '0;
                        n_left           = '0;
                        n_count          = '0;
                        o_push           = 1'b1;
                        o_res.kind       = nfd_pkg::KIND_ERR;
                        o_res.error_code = nfd_pkg::ERR_PREFIX;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= '1;
            r_phase      <= nfd_pkg::PH_PREFIX;
            r_accum      <= '0;
            r_left       <= '0;
            r_count      <= '0;
        end else begin
            if (i_max_length_we) begin
                r_max_length <= i_max_length;
            end
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/nfd_queue.sv
// small result queue between the front and back parts
// depends on nfd_pkg
module nfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nfd_pkg::t_result  i_res,
    input  logic              i_pop,
    output nfd_pkg::t_result  o_head,
    output nfd_pkg::t_q_stat  o_stat
);

    nfd_pkg::t_result           r_mem [nfd_pkg::Q_DEPTH];
    logic [nfd_pkg::Q_AW-1:0]   r_wr_ptr;
    logic [nfd_pkg::Q_AW-1:0]   r_rd_ptr;
    logic [nfd_pkg::Q_AW:0]     r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_stat.full  = (r_count == (nfd_pkg::Q_AW+1)'(nfd_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/nfd_back.sv
// back part: output register that presents queued results on the master stream
// depends on nfd_pkg
module nfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfd_pkg::t_result  i_head,
    input  nfd_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output nfd_pkg::t_result  o_res
);

    logic             r_valid;
    nfd_pkg::t_result r_res;
    logic             load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !i_q_stat.empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
        end
    end

endmodule

// File: hw/rtl/netstring_frame_decoder.sv
// netstring deframer top level: one byte in per transfer, results out per transfer
// depends on nfd_pkg, nfd_front, nfd_queue, nfd_back
// Takes one byte of a netstring stream (digits, ':', payload, ',') per cycle
// while the master side keeps up and gives at most one result per byte: each
// payload byte, an ok result with the declared length at the comma, or an
// error result that ends the frame. A byte is decoded in the cycle it is
// taken; its result passes through the result queue into the output register.
// A four-entry result queue sits ahead of the output register, so
// s_axis_tready drops only once that queue is full. max_length may be written
// only while the block is idle; no clearing pass after reset.
module netstring_frame_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_max_length_we,
    input  logic [nfd_pkg::LEN_BITS-1:0]   i_max_length,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // data, frame_length, error_code
    output logic [1:0]                     m_axis_tuser    // kind
);

    nfd_pkg::t_q_stat q_stat;
    nfd_pkg::t_result push_res;
    nfd_pkg::t_result head;
    nfd_pkg::t_result out_res;
    logic             push;
    logic             pop;

    nfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_length_we (i_max_length_we),
        .i_max_length    (i_max_length),
        .i_valid         (s_axis_tvalid),
        .i_byte          (s_axis_tdata),
        .o_ready         (s_axis_tready),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_res           (push_res)
    );

    nfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    nfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (out_res)
    );

    assign m_axis_tdata = {6'b000000, out_res.error_code, out_res.frame_length, out_res.data};
    assign m_axis_tuser = out_res.kind;

endmodule

// File: hw/rtl/nfd_checker.sv
// port-level checks for the netstring frame decoder, bound to the top level
// depends on nfd_pkg and netstring_frame_decoder
module nfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // nothing shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == nfd_pkg::KIND_DATA)) |->
        (m_axis_tdata[31:8] == '0))
        else $error("payload transfer carries length or error");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == nfd_pkg::KIND_OK)) |->
        ((m_axis_tdata[7:0] == '0) && (m_axis_tdata[31:24] == '0)))
        else $error("ok transfer carries data or error");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == nfd_pkg::KIND_ERR)) |->
        ((m_axis_tdata[25:24] != nfd_pkg::ERR_NONE) && (m_axis_tdata[23:0] == '0)))
        else $error("error transfer malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind netstring_frame_decoder nfd_checker u_nfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/netstring_frame_decoder_test.sv
// self-checking testbench for netstring_frame_decoder: directed and random byte streams
// depends on nfd_pkg and the decoder rtl; expected results come from a frame checker class
module netstring_frame_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nfd_pkg::*;

    class frame_checker;
        t_phase              phase;
        logic [LEN_BITS-1:0] accum;
        logic [LEN_BITS-1:0] left;
        int unsigned         digits;
        logic [LEN_BITS-1:0] max_len;
        t_result             pending_results[$];
        int unsigned         n_fail;
        int unsigned         n_payload;
        int unsigned         n_ok;
        int unsigned         n_err;

        function new();
            max_len   = '1;
            n_fail    = 0;
            n_payload = 0;
            n_ok      = 0;
            n_err     = 0;
            restart();
        endfunction

        function void restart();
            phase  = PH_PREFIX;
            accum  = '0;
            left   = '0;
            digits = 0;
        endfunction

        function void set_max_length(logic [LEN_BITS-1:0] v);
            max_len = v;
        endfunction

        function bit in_prefix();
            return phase == PH_PREFIX;
        endfunction

        function bit at_frame_start();
            return phase == PH_PREFIX && digits == 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_error(t_err code);
            t_result r;
            r.kind         = KIND_ERR;
            r.data         = '0;
            r.frame_length = '0;
            r.error_code   = code;
            restart();
            pending_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            t_result     r;
            int unsigned nxt;
            r.kind         = KIND_DATA;
            r.data         = '0;
            r.frame_length = '0;
            r.error_code   = ERR_NONE;
            case (phase)
                PH_PAYLOAD: begin
                    left = left - 1'b1;
                    if (left == 0) begin
                        phase = PH_COMMA;
                    end
                    r.data = b;
                    pending_results.push_back(r);
                end
                PH_COMMA: begin
                    if (b == CH_COMMA) begin
                        r.kind         = KIND_OK;
                        r.frame_length = accum;
                        restart();
                        pending_results.push_back(r);
                    end else begin
                        push_error(ERR_COMMA);
                    end
                end
                default: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        nxt = int'(accum) * 10 + int'(b - CH_ZERO);
                        if (digits >= MAX_DIGITS || nxt > int'(max_len)) begin
                            push_error(ERR_TOO_LARGE);
                        end else begin
                            accum  = nxt[LEN_BITS-1:0];
                            digits = digits + 1;
                        end
                    end else if (b == CH_COLON) begin
                        if (digits == 0) begin
                            push_error(ERR_PREFIX);
                        end else begin
                            left   = accum;
                            digits = 0;
                            phase  = (accum == 0) ? PH_COMMA : PH_PAYLOAD;
                        end
                    end else begin
                        push_error(ERR_PREFIX);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data,
                                   logic [LEN_BITS-1:0] flen, logic [1:0] ecode);
            t_result want;
            case (kind)
                KIND_DATA: n_payload++;
                KIND_OK:   n_ok++;
                default:   n_err++;
            endcase
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("unexpected result: kind %0d data %02h len %0d err %0d",
                             kind, data, flen, ecode);
                end
            end else begin
                want = pending_results.pop_front();
                if (kind != want.kind || data != want.data ||
                    flen != want.frame_length || ecode != want.error_code) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("mismatch: expected kind %0d data %02h len %0d err %0d",
                                 want.kind, want.data, want.frame_length,
                                 want.error_code);
                        $display("          got kind %0d data %02h len %0d err %0d",
                                 kind, data, flen, ecode);
                    end
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_max_length_we = 1'b0;
    logic [LEN_BITS-1:0] i_max_length = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;    // in_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;         // data, frame_length, error_code
    logic [1:0]          m_axis_tuser;         // kind

    frame_checker sb = new();

    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;
    int unsigned n_bytes = 0;
    int unsigned n_settings = 0;

    netstring_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_length_we (i_max_length_we),
        .i_max_length    (i_max_length),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
                            m_axis_tdata[25:24]);
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_stalls ? int'($urandom_range(0, 17)) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gaps ? int'($urandom_range(0, 17)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_decimal(input int unsigned v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) send_byte(CH_ZERO);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic write_max_length(input logic [LEN_BITS-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_max_length_we <= 1'b1;
        i_max_length    <= v;
        @(negedge i_clk);
        i_max_length_we <= 1'b0;
        sb.set_max_length(v);
        n_settings++;
    endtask

    // bring the decoder back to the start of a length prefix
    task automatic resync();
        while (!sb.at_frame_start()) begin
            if (sb.in_prefix()) begin
                send_byte(8'h2F);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_random_frame();
        int unsigned sel;
        int unsigned cap;
        int unsigned len;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        cap = (sb.max_len < 12) ? sb.max_len : 12;
        if ($urandom_range(0, 9) == 0) begin
            cap = (sb.max_len < 60) ? sb.max_len : 60;
        end
        len = $urandom_range(0, cap);
        resync();
        if (sel < 70 || (sel >= 85 && sel < 93)) begin
            send_decimal(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            send_byte(CH_COLON);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            if (sel < 70) begin
                send_byte(CH_COMMA);
            end else begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
                send_byte(b);
            end
        end else if (sel < 75) begin
            if ($urandom_range(0, 1) == 1) begin
                send_decimal($urandom_range(0, 99), 0);
            end
            do b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
            send_byte(b);
        end else if (sel < 78) begin
            send_byte(CH_COLON);
        end else if (sel < 82) begin
            send_decimal(int'(sb.max_len) + 1 + $urandom_range(0, 1000), 0);
        end else if (sel < 85) begin
            repeat (MAX_DIGITS) send_byte(CH_ZERO);
            send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0]          directed[$];
        logic [LEN_BITS-1:0] settings[5];
        int unsigned         target;

        directed = '{"0", ":", ",", "2", ":", 8'h00, 8'hFF, ",", ":", "/", ";",
                     "6", "5", "5", "3", "6",
                     "0", "0", "0", "0", "0", "0", "0", "0", "0",
                     "0", ":", ":"};
        settings = '{16'd0, 16'd9, 16'hFFFF, 16'd300, 16'd0};
        settings[4] = 16'($urandom_range(1, 65534));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_byte(directed[i]);

        foreach (settings[p]) begin
            write_max_length(settings[p]);
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            // max 0 only admits the empty frame; any nonzero length digit is too large
            if (settings[p] == 0) begin
                send_decimal(0, 0);
                send_byte(CH_COLON);
                send_byte(CH_COMMA);
                send_byte("1");
            end
            target = n_bytes + 100;
            while (n_bytes < target) send_random_frame();
        end
        resync();
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes over %0d max_length settings plus reset value",
                 n_bytes, n_settings);
        $display("checked %0d payload, %0d ok and %0d error results",
                 sb.n_payload, sb.n_ok, sb.n_err);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures, %0d results outstanding", sb.n_fail, sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
